[hdl/avc_l2s_pkg.sv]
// Shared types, codes and constants of the length-prefixed to start-code converter.
`default_nettype none
package avc_l2s_pkg;
  localparam int unsigned PrefixDepthDefault = 32;
  localparam int unsigned SampleSizeBitsDefault = 24;
  localparam int unsigned LookDepth = 5;
  localparam int unsigned AccBits = 32;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_PREFIX = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  localparam logic [1:0] CMD_PFX   = 2'd0;
  localparam logic [1:0] CMD_EMPTY = 2'd1;
  localparam logic [1:0] CMD_NEW   = 2'd2;
  localparam logic [1:0] CMD_BYTE  = 2'd3;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_LOOK    = 2'd1;
  localparam logic [1:0] PH_LENGTH  = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [4:0] AUD_TYPE = 5'd9;
  localparam logic [7:0] AUD_PAYLOAD = 8'hE0;
  localparam logic [2:0] LEN_RESET = 3'd4;

  typedef struct packed {
    logic [1:0] code;
    logic [7:0] data;
    logic       first;
  } cmd_t;

  function automatic logic [7:0] delim_byte(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd3: r = 8'h01;
      3'd4: r = {3'b000, AUD_TYPE};
      3'd5: r = AUD_PAYLOAD;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] start_byte(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd2: r = 8'h01;
      default: r = 8'h00;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

[hdl/avc_l2s_front.sv]
// Input queue: accepts items, classifies them and queues commands for the back end.
`default_nettype none
module avc_l2s_front #(
  parameter int unsigned SAMPLE_SIZE_BITS = avc_l2s_pkg::SampleSizeBitsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [7:0]                  data_byte_i,
  input  wire logic                        first_i,
  input  wire logic [23:0]                 sample_size_i,
  output logic                             cmd_valid_o,
  output avc_l2s_pkg::cmd_t                cmd_o,
  output logic [SAMPLE_SIZE_BITS-1:0]      cmd_size_o,
  input  wire logic                        cmd_pop_i
);
  avc_l2s_pkg::cmd_t             mem_cmd [2];
  logic [SAMPLE_SIZE_BITS-1:0]   mem_size [2];
  logic                          wp_q, rp_q;
  logic [1:0]                    cnt_q;
  logic [31:0]                   size_ext;
  logic [SAMPLE_SIZE_BITS-1:0]   size_m;
  avc_l2s_pkg::cmd_t             cmd_new;
  logic                          keep, wr, rd;

  assign size_ext = 32'(sample_size_i);
  assign size_m = size_ext[SAMPLE_SIZE_BITS-1:0];

  always_comb begin
    cmd_new.data = data_byte_i;
    cmd_new.first = first_i;
    cmd_new.code = avc_l2s_pkg::CMD_BYTE;
    keep = 1'b1;
    case (kind_i)
      avc_l2s_pkg::KIND_PREFIX: cmd_new.code = avc_l2s_pkg::CMD_PFX;
      avc_l2s_pkg::KIND_EMPTY: cmd_new.code = avc_l2s_pkg::CMD_EMPTY;
      avc_l2s_pkg::KIND_SAMPLE: begin
        if (first_i && size_m == '0) begin
          cmd_new.code = avc_l2s_pkg::CMD_EMPTY;
        end else if (first_i) begin
          cmd_new.code = avc_l2s_pkg::CMD_NEW;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  assign full = (cnt_q == 2'd2);
  assign wr = push && !full && keep;
  assign rd = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = mem_cmd[rp_q];
  assign cmd_size_o = mem_size[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_cmd[wp_q] <= cmd_new;
      mem_size[wp_q] <= size_m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end
endmodule
`default_nettype wire

[hdl/avc_l2s_back.sv]
// Sequencer: parses length fields, emits delimiter, prefix, start codes and payload.
`default_nettype none
module avc_l2s_back #(
  parameter int unsigned PREFIX_DEPTH = avc_l2s_pkg::PrefixDepthDefault,
  parameter int unsigned SAMPLE_SIZE_BITS = avc_l2s_pkg::SampleSizeBitsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [2:0]                  cfg_data_i,
  input  wire logic                        cmd_valid_i,
  input  wire avc_l2s_pkg::cmd_t           cmd_i,
  input  wire logic [SAMPLE_SIZE_BITS-1:0] cmd_size_i,
  output logic                             cmd_pop_o,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [7:0]                       out_byte_o,
  output logic                             last_o
);
  localparam int unsigned SB = SAMPLE_SIZE_BITS;
  localparam int unsigned RW = SB + 1;
  localparam int unsigned PW = $clog2(PREFIX_DEPTH + 1);
  localparam int unsigned IW = (PW > 3) ? PW : 3;
  localparam int unsigned AW = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;
  localparam int unsigned AB = avc_l2s_pkg::AccBits;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PARSE = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_FIN = 2'd3;

  logic [7:0]    pstore [PREFIX_DEPTH];
  logic [7:0]    la [avc_l2s_pkg::LookDepth];
  logic [PW-1:0] pcnt_q, pcnt_d;
  logic [1:0]    state_q, state_d, phase_q, phase_d;
  logic [SB-1:0] bl_q, bl_d;
  logic [AB-1:0] acc_q, acc_d, ubl_q, ubl_d;
  logic [2:0]    lbs_q, lbs_d, len_q, ri_q, ri_d, n_q, n_d;
  logic          seen_q, seen_d, done_q, done_d, stop_q, stop_d;
  logic          pl_delim_q, pl_delim_d, pl_byte_q, pl_byte_d, pl_pfxa_q, pl_pfxa_d;
  logic          pl_start_q, pl_start_d, pl_pfxb_q, pl_pfxb_d;
  logic [7:0]    pl_val_q, pl_val_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          pend_v_q, pend_v_d;
  logic [7:0]    pend_b_q, pend_b_d;
  logic          pfx_we, la_we, emit_v, fin_push, room;
  logic [AW-1:0] pfx_wa;
  logic [2:0]    la_wa;
  logic [7:0]    emit_b, pb, look_b;
  logic [1:0]    ph_e;
  logic [SB-1:0] bl_e, bl_n;
  logic [2:0]    lbs_e, lbs_n, look_i;
  logic [3:0]    need;
  logic          seen_n, len_ok, done_a;
  logic [RW-1:0] rem;
  logic [32:0]   rem_m1;
  logic [AB-1:0] acc_n, ubl_n;
  logic [PW-1:0] pcnt_m1;
  logic [8:0]    of_mem [2];
  logic          of_wp_q, of_rp_q, of_push, of_pop;
  logic [1:0]    of_cnt_q;

  assign cfg_ready = 1'b1;
  assign room = !pend_v_q || (of_cnt_q != 2'd2);
  assign pb = la[ri_q];
  assign rem = RW'(bl_q) + RW'(n_q - ri_q);
  assign rem_m1 = 33'(rem) - 33'd1;
  assign len_ok = (len_q == 3'd1) || (len_q == 3'd2) || (len_q == 3'd4);
  assign pcnt_m1 = pcnt_q - PW'(1);
  assign look_i = (len_q <= 3'd4) ? len_q : 3'd0;

  always_comb begin
    ph_e = (cmd_i.code == avc_l2s_pkg::CMD_NEW) ? avc_l2s_pkg::PH_LOOK : phase_q;
    bl_e = (cmd_i.code == avc_l2s_pkg::CMD_NEW) ? cmd_size_i : bl_q;
    lbs_e = (cmd_i.code == avc_l2s_pkg::CMD_NEW) ? 3'd0 : lbs_q;
    lbs_n = (lbs_e < 3'(avc_l2s_pkg::LookDepth)) ? lbs_e + 3'd1 : lbs_e;
    bl_n = bl_e - SB'(1);
    need = (len_q <= 3'd4) ? 4'(len_q) + 4'd1 : 4'd1;
    look_b = (look_i == lbs_e) ? cmd_i.data : la[look_i];
    seen_n = (len_q <= 3'd4) && (lbs_n > len_q) &&
             ((look_b[4:0] & avc_l2s_pkg::NAL_TYPE_MASK) == avc_l2s_pkg::AUD_TYPE);
    acc_n = ((lbs_q == 3'd0) ? AB'(0) : (acc_q << 8)) | AB'(pb);
    ubl_n = ubl_q - AB'(1);
    done_a = done_q || (!seen_q && !done_q);
  end

  always_comb begin
    state_d = state_q; phase_d = phase_q; bl_d = bl_q; acc_d = acc_q; ubl_d = ubl_q;
    lbs_d = lbs_q; seen_d = seen_q; done_d = done_q; stop_d = stop_q; pcnt_d = pcnt_q;
    pl_delim_d = pl_delim_q; pl_byte_d = pl_byte_q; pl_pfxa_d = pl_pfxa_q;
    pl_start_d = pl_start_q; pl_pfxb_d = pl_pfxb_q; pl_val_d = pl_val_q;
    idx_d = idx_q; ri_d = ri_q; n_d = n_q; pend_v_d = pend_v_q; pend_b_d = pend_b_q;
    cmd_pop_o = 1'b0; pfx_we = 1'b0; pfx_wa = '0; la_we = 1'b0; la_wa = 3'd0;
    emit_v = 1'b0; emit_b = 8'h00; fin_push = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          idx_d = '0;
          ri_d = 3'd0;
          case (cmd_i.code)
            avc_l2s_pkg::CMD_PFX: begin
              if (cmd_i.first) begin
                pfx_we = 1'b1;
                pcnt_d = PW'(1);
              end else if (pcnt_q < PW'(PREFIX_DEPTH)) begin
                pfx_we = 1'b1;
                pfx_wa = pcnt_q[AW-1:0];
                pcnt_d = pcnt_q + PW'(1);
              end
            end
            avc_l2s_pkg::CMD_EMPTY: begin
              phase_d = avc_l2s_pkg::PH_IDLE;
              bl_d = '0;
              pl_delim_d = 1'b1;
              n_d = 3'd0;
              state_d = S_EMIT;
            end
            default: begin
              if (cmd_i.code == avc_l2s_pkg::CMD_NEW) begin
                phase_d = avc_l2s_pkg::PH_LOOK; bl_d = cmd_size_i; lbs_d = 3'd0;
                acc_d = '0; ubl_d = '0; seen_d = 1'b0; done_d = 1'b0; stop_d = 1'b0;
              end
              if (ph_e == avc_l2s_pkg::PH_LOOK) begin
                la_we = (lbs_e < 3'(avc_l2s_pkg::LookDepth));
                la_wa = lbs_e;
                bl_d = bl_n;
                lbs_d = lbs_n;
                if (4'(lbs_n) >= need || bl_n == '0) begin
                  seen_d = seen_n;
                  lbs_d = 3'd0;
                  phase_d = avc_l2s_pkg::PH_LENGTH;
                  pl_delim_d = !seen_n;
                  n_d = lbs_n;
                  state_d = S_EMIT;
                end
              end else if (ph_e != avc_l2s_pkg::PH_IDLE) begin
                la_we = 1'b1;
                bl_d = bl_n;
                n_d = 3'd1;
                state_d = S_PARSE;
              end
            end
          endcase
        end
      end
      S_PARSE: begin
        ri_d = ri_q + 3'd1;
        idx_d = '0;
        state_d = S_EMIT;
        if (stop_q) begin
        end else if (phase_q == avc_l2s_pkg::PH_PAYLOAD) begin
          pl_byte_d = 1'b1;
          pl_val_d = pb;
          ubl_d = ubl_n;
          if (ubl_n == '0) begin
            if (seen_q && !done_q) begin
              done_d = 1'b1;
              pl_pfxb_d = (pcnt_q != '0);
            end
            phase_d = avc_l2s_pkg::PH_LENGTH;
          end
        end else if (lbs_q == 3'd0 && (rem < RW'(len_q) || !len_ok)) begin
          stop_d = 1'b1;
        end else if (lbs_q + 3'd1 < len_q) begin
          acc_d = acc_n;
          lbs_d = lbs_q + 3'd1;
        end else begin
          lbs_d = 3'd0;
          acc_d = acc_n;
          if (33'(acc_n) > rem_m1) begin
            stop_d = 1'b1;
          end else begin
            pl_pfxa_d = !seen_q && !done_q && (pcnt_q != '0);
            pl_start_d = 1'b1;
            if (acc_n == '0) begin
              pl_pfxb_d = !done_a && (pcnt_q != '0);
              done_d = 1'b1;
              phase_d = avc_l2s_pkg::PH_LENGTH;
            end else begin
              done_d = done_a;
              ubl_d = acc_n;
              phase_d = avc_l2s_pkg::PH_PAYLOAD;
            end
          end
        end
      end
      S_EMIT: begin
        if (!(pl_delim_q || pl_byte_q || pl_pfxa_q || pl_start_q || pl_pfxb_q)) begin
          state_d = (ri_q < n_q) ? S_PARSE : S_FIN;
        end else if (room) begin
          emit_v = 1'b1;
          idx_d = idx_q + IW'(1);
          if (pl_delim_q) begin
            emit_b = avc_l2s_pkg::delim_byte(idx_q[2:0]);
            if (idx_q == IW'(5)) begin
              pl_delim_d = 1'b0;
              idx_d = '0;
            end
          end else if (pl_byte_q) begin
            emit_b = pl_val_q;
            pl_byte_d = 1'b0;
            idx_d = '0;
          end else if (pl_pfxa_q || (!pl_start_q && pl_pfxb_q)) begin
            emit_b = pstore[idx_q[AW-1:0]];
            if (idx_q == IW'(pcnt_m1)) begin
              idx_d = '0;
              if (pl_pfxa_q) pl_pfxa_d = 1'b0;
              else pl_pfxb_d = 1'b0;
            end
          end else begin
            emit_b = avc_l2s_pkg::start_byte(idx_q[1:0]);
            if (idx_q == IW'(2)) begin
              pl_start_d = 1'b0;
              idx_d = '0;
            end
          end
          pend_v_d = 1'b1;
          pend_b_d = emit_b;
        end
      end
      default: begin
        if (room) begin
          fin_push = pend_v_q;
          pend_v_d = 1'b0;
          if (bl_q == '0) phase_d = avc_l2s_pkg::PH_IDLE;
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pfx_we) pstore[pfx_wa] <= cmd_i.data;
    if (la_we) la[la_wa] <= cmd_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; phase_q <= avc_l2s_pkg::PH_IDLE; bl_q <= '0; acc_q <= '0;
      ubl_q <= '0; lbs_q <= 3'd0; seen_q <= 1'b0; done_q <= 1'b0; stop_q <= 1'b0;
      pcnt_q <= '0; len_q <= avc_l2s_pkg::LEN_RESET;
      pl_delim_q <= 1'b0; pl_byte_q <= 1'b0; pl_pfxa_q <= 1'b0;
      pl_start_q <= 1'b0; pl_pfxb_q <= 1'b0;
      idx_q <= '0; ri_q <= 3'd0; n_q <= 3'd0; pend_v_q <= 1'b0;
    end else begin
      state_q <= state_d; phase_q <= phase_d; bl_q <= bl_d; acc_q <= acc_d;
      ubl_q <= ubl_d; lbs_q <= lbs_d; seen_q <= seen_d; done_q <= done_d; stop_q <= stop_d;
      pcnt_q <= pcnt_d;
      if (cfg_valid) len_q <= cfg_data_i;
      pl_delim_q <= pl_delim_d; pl_byte_q <= pl_byte_d; pl_pfxa_q <= pl_pfxa_d;
      pl_start_q <= pl_start_d; pl_pfxb_q <= pl_pfxb_d;
      idx_q <= idx_d; ri_q <= ri_d; n_q <= n_d; pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_val_q <= pl_val_d;
    pend_b_q <= pend_b_d;
  end

  assign of_push = (emit_v && pend_v_q) || fin_push;
  assign of_pop = pop && !empty;
  assign empty = (of_cnt_q == 2'd0);
  assign out_byte_o = of_mem[of_rp_q][8:1];
  assign last_o = of_mem[of_rp_q][0];

  always_ff @(posedge clk_i) begin
    if (of_push) of_mem[of_wp_q] <= {pend_b_q, fin_push};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      of_wp_q <= 1'b0;
      of_rp_q <= 1'b0;
      of_cnt_q <= 2'd0;
    end else begin
      if (of_push) of_wp_q <= !of_wp_q;
      if (of_pop) of_rp_q <= !of_rp_q;
      of_cnt_q <= of_cnt_q + 2'(of_push) - 2'(of_pop);
    end
  end

  a_pcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= PW'(PREFIX_DEPTH)) else $error("prefix count past depth");
  a_idle_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_v_q) else $error("pending byte left at idle");
  a_of_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    of_cnt_q <= 2'd2) else $error("output queue overflow");
  a_stop_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PARSE && stop_q) |=> (!pl_byte_q && !pl_start_q))
    else $error("emission after stop");
endmodule
`default_nettype wire

[hdl/avc_length_to_start_code.sv]
// Top level of the length-prefixed to Annex B start-code converter.
// The back end takes one command at a time: a copied payload byte goes through the parse, emit
// and finish states before the next command is popped; a lookahead byte that decides nothing is
// taken in the idle state. Delimiter, start-code and prefix bytes come from the emit state.
// Input queue holds 2 items and the output queue 2 results; both sides stall independently.
// Reset clears all control state; length field size resets to 4, prefix store is unwritten.
`default_nettype none
module avc_length_to_start_code #(
  parameter int unsigned PREFIX_DEPTH = avc_l2s_pkg::PrefixDepthDefault,
  parameter int unsigned SAMPLE_SIZE_BITS = avc_l2s_pkg::SampleSizeBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        first_i,
  input  wire logic [23:0] sample_size_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte_o,
  output logic             last_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data_i
);
  logic                        cmd_valid, cmd_pop;
  avc_l2s_pkg::cmd_t           cmd;
  logic [SAMPLE_SIZE_BITS-1:0] cmd_size;

  avc_l2s_front #(.SAMPLE_SIZE_BITS(SAMPLE_SIZE_BITS)) u_front (
    .clk_i, .rst_ni, .push, .full, .kind_i, .data_byte_i, .first_i, .sample_size_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_size_o(cmd_size), .cmd_pop_i(cmd_pop)
  );

  avc_l2s_back #(.PREFIX_DEPTH(PREFIX_DEPTH), .SAMPLE_SIZE_BITS(SAMPLE_SIZE_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_data_i,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_size_i(cmd_size), .cmd_pop_o(cmd_pop),
    .empty, .pop, .out_byte_o, .last_o
  );
endmodule
`default_nettype wire
